@@ rtl/core/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX1   = 3'd2,
    PH_BSLASH = 3'd3,
    PH_LOWU   = 3'd4,
    PH_HEX2   = 3'd5
  } phase_t;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] err_t;

  localparam kind_t KindData  = 2'd0;
  localparam kind_t KindClose = 2'd1;
  localparam kind_t KindError = 2'd2;

  localparam err_t ErrNone      = 3'd0;
  localparam err_t ErrNul       = 3'd1;
  localparam err_t ErrEscape    = 3'd2;
  localparam err_t ErrHex       = 3'd3;
  localparam err_t ErrSurrogate = 3'd4;
  localparam err_t ErrEarlyEnd  = 3'd5;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowEnd    = 16'hE000;
  localparam logic [20:0] SuppBase  = 21'h10000;

endpackage
`default_nettype wire

@@ rtl/core/json_string_unescaper_unit.sv @@
// the first result of a request shows on out_* in the cycle after it is accepted
// throughput: one request per cycle while each gives at most one result and out_tready is high;
//   a \u escape that decodes to several utf-8 bytes holds the 4-entry result register until all are taken
// in_tready stays high when the result register drains its last entry in the same cycle
// reset (rst_n low, synchronous): normal phase, escape state cleared, allow_nul = 0,
//   result register empty
`default_nettype none
module json_string_unescaper_unit import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,     // allow_nul
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // [7:0] in_byte
  input  wire logic [0:0] in_tuser,      // [0] stream_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,     // [7:0] out_byte
  output logic [4:0]      out_tuser,     // [1:0] kind, [4:2] error_code
  output logic            out_tlast      // last_of_run
);

  logic        allow_nul_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] hex_acc_r, hex_acc_nxt;
  logic [9:0]  high_half_r, high_half_nxt;

  logic [7:0]  buf_byte_r [MaxRes];
  kind_t       buf_kind_r;
  err_t        buf_code_r;
  logic [2:0]  buf_cnt_r;
  logic [1:0]  buf_idx_r;

  logic        in_fire, out_fire;
  logic [7:0]  c;
  logic        dig_ok;
  logic [3:0]  dig;
  logic [15:0] hex_val;
  logic [20:0] enc_cp;
  logic [2:0]  enc_n;
  logic [7:0]  enc_b [MaxRes];

  logic [2:0]  res_n;
  kind_t       res_kind;
  err_t        res_code;
  logic [7:0]  res_b [MaxRes];

  assign c        = in_tdata;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready = (buf_cnt_r == 3'd0) || ((buf_cnt_r == 3'd1) && out_tready);
  assign in_fire  = in_tvalid && in_tready;

  assign out_tvalid = (buf_cnt_r != 3'd0);
  assign out_tdata  = buf_byte_r[buf_idx_r];
  assign out_tuser  = {buf_code_r, buf_kind_r};
  assign out_tlast  = (buf_cnt_r == 3'd1);

  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      dig = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      dig = c[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign hex_val = {hex_acc_r, dig};

  // second half of a pair combines with the stored high half
  assign enc_cp = (phase_r == PH_HEX2) ? (SuppBase + {1'b0, high_half_r, hex_val[9:0]})
                                       : {5'd0, hex_val};

  always_comb begin
    enc_b[0] = 8'd0;
    enc_b[1] = 8'd0;
    enc_b[2] = 8'd0;
    enc_b[3] = 8'd0;
    if (enc_cp < 21'h80) begin
      enc_n    = 3'd1;
      enc_b[0] = enc_cp[7:0];
    end else if (enc_cp < 21'h800) begin
      enc_n    = 3'd2;
      enc_b[0] = {3'b110, enc_cp[10:6]};
      enc_b[1] = {2'b10, enc_cp[5:0]};
    end else if (enc_cp < 21'h10000) begin
      enc_n    = 3'd3;
      enc_b[0] = {4'b1110, enc_cp[15:12]};
      enc_b[1] = {2'b10, enc_cp[11:6]};
      enc_b[2] = {2'b10, enc_cp[5:0]};
    end else begin
      enc_n    = 3'd4;
      enc_b[0] = {5'b11110, enc_cp[20:18]};
      enc_b[1] = {2'b10, enc_cp[17:12]};
      enc_b[2] = {2'b10, enc_cp[11:6]};
      enc_b[3] = {2'b10, enc_cp[5:0]};
    end
  end

  always_comb begin
    logic fail;
    logic nul;
    logic enc;
    err_t fcode;
    phase_nxt     = phase_r;
    hex_cnt_nxt   = hex_cnt_r;
    hex_acc_nxt   = hex_acc_r;
    high_half_nxt = high_half_r;
    res_n         = 3'd0;
    res_kind      = KindData;
    res_code      = ErrNone;
    res_b[0]      = 8'd0;
    res_b[1]      = 8'd0;
    res_b[2]      = 8'd0;
    res_b[3]      = 8'd0;
    fail          = 1'b0;
    nul           = 1'b0;
    enc           = 1'b0;
    fcode         = ErrNone;

    if (in_tuser[0]) begin
      fail  = 1'b1;
      fcode = ErrEarlyEnd;
    end else begin
      case (phase_r)
        PH_NORMAL: begin
          if (c == ChBslash) begin
            phase_nxt = PH_ESC;
          end else if (c == ChQuote) begin
            res_n    = 3'd1;
            res_kind = KindClose;
          end else if (c == 8'd0) begin
            nul = 1'b1;
          end else begin
            res_n    = 3'd1;
            res_b[0] = c;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_NORMAL;
          res_n     = 3'd1;
          case (c)
            ChQuote:  res_b[0] = ChQuote;
            ChSlash:  res_b[0] = ChSlash;
            ChBslash: res_b[0] = ChBslash;
            ChB:      res_b[0] = CtlBs;
            ChF:      res_b[0] = CtlFf;
            ChN:      res_b[0] = CtlLf;
            ChR:      res_b[0] = CtlCr;
            ChT:      res_b[0] = CtlTab;
            ChZero: begin
              res_n = 3'd0;
              nul   = 1'b1;
            end
            ChU: begin
              res_n       = 3'd0;
              phase_nxt   = PH_HEX1;
              hex_cnt_nxt = 2'd0;
              hex_acc_nxt = 12'd0;
            end
            default: begin
              res_n = 3'd0;
              fail  = 1'b1;
              fcode = ErrEscape;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!dig_ok) begin
            fail  = 1'b1;
            fcode = ErrHex;
          end else if (hex_cnt_r != 2'd3) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            hex_acc_nxt = {hex_acc_r[7:0], dig};
          end else begin
            hex_cnt_nxt = 2'd0;
            hex_acc_nxt = 12'd0;
            if (phase_r == PH_HEX1) begin
              if (hex_val >= LowFirst && hex_val < LowEnd) begin
                fail  = 1'b1;
                fcode = ErrSurrogate;
              end else if (hex_val >= HighFirst && hex_val < LowFirst) begin
                high_half_nxt = hex_val[9:0];
                phase_nxt     = PH_BSLASH;
              end else begin
                phase_nxt = PH_NORMAL;
                if (hex_val == 16'd0) begin
                  nul = 1'b1;
                end else begin
                  enc = 1'b1;
                end
              end
            end else begin
              if (hex_val < LowFirst || hex_val >= LowEnd) begin
                fail  = 1'b1;
                fcode = ErrSurrogate;
              end else begin
                phase_nxt     = PH_NORMAL;
                high_half_nxt = 10'd0;
                enc           = 1'b1;
              end
            end
          end
        end
        PH_BSLASH: begin
          if (c != ChBslash) begin
            fail  = 1'b1;
            fcode = ErrSurrogate;
          end else begin
            phase_nxt = PH_LOWU;
          end
        end
        PH_LOWU: begin
          if (c != ChU) begin
            fail  = 1'b1;
            fcode = ErrSurrogate;
          end else begin
            phase_nxt   = PH_HEX2;
            hex_cnt_nxt = 2'd0;
            hex_acc_nxt = 12'd0;
          end
        end
        default: begin
          phase_nxt     = PH_NORMAL;
          hex_cnt_nxt   = 2'd0;
          hex_acc_nxt   = 12'd0;
          high_half_nxt = 10'd0;
        end
      endcase
    end

    // escaped or raw nul behaves the same
    if (nul) begin
      if (allow_nul_r) begin
        res_n    = 3'd1;
        res_b[0] = 8'd0;
      end else begin
        fail  = 1'b1;
        fcode = ErrNul;
      end
    end

    if (enc) begin
      res_n    = enc_n;
      res_b[0] = enc_b[0];
      res_b[1] = enc_b[1];
      res_b[2] = enc_b[2];
      res_b[3] = enc_b[3];
    end

    if (fail) begin
      phase_nxt     = PH_NORMAL;
      hex_cnt_nxt   = 2'd0;
      hex_acc_nxt   = 12'd0;
      high_half_nxt = 10'd0;
      res_n         = 3'd1;
      res_kind      = KindError;
      res_code      = fcode;
      res_b[0]      = 8'd0;
      res_b[1]      = 8'd0;
      res_b[2]      = 8'd0;
      res_b[3]      = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_nul_r <= 1'b0;
      phase_r     <= PH_NORMAL;
      hex_cnt_r   <= 2'd0;
      hex_acc_r   <= 12'd0;
      high_half_r <= 10'd0;
      buf_cnt_r   <= 3'd0;
      buf_idx_r   <= 2'd0;
    end else begin
      if (cfg_we) begin
        allow_nul_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        hex_cnt_r   <= hex_cnt_nxt;
        hex_acc_r   <= hex_acc_nxt;
        high_half_r <= high_half_nxt;
        buf_cnt_r   <= res_n;
        buf_idx_r   <= 2'd0;
      end else if (out_fire) begin
        buf_cnt_r <= buf_cnt_r - 3'd1;
        buf_idx_r <= buf_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_byte_r[0] <= res_b[0];
      buf_byte_r[1] <= res_b[1];
      buf_byte_r[2] <= res_b[2];
      buf_byte_r[3] <= res_b[3];
      buf_kind_r    <= res_kind;
      buf_code_r    <= res_code;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= 3'(MaxRes))
    else $error("result count out of range");

  a_ctl_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != KindData) |-> out_tlast)
    else $error("close or error result not alone");

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (res_kind == KindError) |=> (phase_r == PH_NORMAL) && (hex_cnt_r == 2'd0)
      && (high_half_r == 10'd0))
    else $error("state not cleared after error");

  a_hex_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_cnt_r != 2'd0) |-> (phase_r == PH_HEX1) || (phase_r == PH_HEX2))
    else $error("hex digit count outside hex phase");

  a_fire_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (res_n != 3'd0) |=> out_tvalid && (buf_idx_r == 2'd0))
    else $error("new results not presented from first slot");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } req_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       nul;
    logic       typed;
    kind_t      kind;
    err_t       err;
    logic [7:0] data;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic [0:0] in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  // predictor state
  phase_t      esc_ph;
  logic [1:0]  hcnt;
  logic [15:0] hacc;
  logic [9:0]  hhalf;
  logic        nul_ok;

  res_t decoded_q [$];
  res_t step_out [$];
  req_t tok [$];

  int send_idle = 31;
  int recv_idle = 72;
  int hold_left = 0;
  int n_req = 0;
  int n_res = 0;
  int n_close = 0;
  int n_fault = 0;
  int n_err = 0;

  logic [7:0] esc_letters [9] = '{ChQuote, ChSlash, ChBslash, ChB, ChF, ChN, ChR, ChT, ChZero};

  // in_byte, stream_end, allow_nul, typed, kind, code, out_byte
  row_t dir_tab [0:25] = '{
    '{8'h41,    1'b0, 1'b0, 1'b1, KindData,  ErrNone,     8'h41},
    '{8'hFF,    1'b0, 1'b0, 1'b1, KindData,  ErrNone,     8'hFF},
    '{8'h00,    1'b0, 1'b0, 1'b1, KindError, ErrNul,      8'h00},
    '{ChQuote,  1'b0, 1'b0, 1'b1, KindClose, ErrNone,     8'h00},
    '{ChBslash, 1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"q",      1'b0, 1'b0, 1'b1, KindError, ErrEscape,   8'h00},
    '{ChBslash, 1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChZero,   1'b0, 1'b0, 1'b1, KindError, ErrNul,      8'h00},
    // surrogate pair, four utf-8 bytes out
    '{ChBslash, 1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChU,      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"D",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"8",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"3",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"d",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChBslash, 1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChU,      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"D",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"E",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"0",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"0",      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChBslash, 1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{ChU,      1'b0, 1'b0, 1'b0, KindData,  ErrNone,     8'h00},
    '{"g",      1'b0, 1'b0, 1'b1, KindError, ErrHex,      8'h00},
    '{8'h00,    1'b0, 1'b1, 1'b1, KindData,  ErrNone,     8'h00},
    '{ChQuote,  1'b0, 1'b1, 1'b1, KindClose, ErrNone,     8'h00},
    '{8'hA5,    1'b1, 1'b1, 1'b1, KindError, ErrEarlyEnd, 8'h00}
  };

  json_string_unescaper_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- unescape predictor ----------------

  task automatic clear_esc();
    esc_ph = PH_NORMAL;
    hcnt = 2'd0;
    hacc = 16'h0000;
    hhalf = 10'h000;
  endtask

  task automatic put_res(input logic [7:0] d, input kind_t k, input err_t e);
    res_t r;
    r.data = d;
    r.kind = k;
    r.err = e;
    r.last = 1'b0;
    step_out.insert(step_out.size(), r);
  endtask

  task automatic abort_esc(input err_t e);
    clear_esc();
    put_res(8'h00, KindError, e);
  endtask

  task automatic nul_char();
    if (!nul_ok) abort_esc(ErrNul);
    else put_res(8'h00, KindData, ErrNone);
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp == 21'd0) begin
      nul_char();
    end else if (cp < 21'h80) begin
      put_res(cp[7:0], KindData, ErrNone);
    end else if (cp < 21'h800) begin
      put_res({3'b110, cp[10:6]}, KindData, ErrNone);
      put_res({2'b10, cp[5:0]}, KindData, ErrNone);
    end else if (cp < 21'h10000) begin
      put_res({4'b1110, cp[15:12]}, KindData, ErrNone);
      put_res({2'b10, cp[11:6]}, KindData, ErrNone);
      put_res({2'b10, cp[5:0]}, KindData, ErrNone);
    end else begin
      put_res({5'b11110, cp[20:18]}, KindData, ErrNone);
      put_res({2'b10, cp[17:12]}, KindData, ErrNone);
      put_res({2'b10, cp[11:6]}, KindData, ErrNone);
      put_res({2'b10, cp[5:0]}, KindData, ErrNone);
    end
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic unescape_step(input logic [7:0] c, input logic eos);
    int d;
    logic [15:0] v;
    logic [20:0] cp;
    step_out.delete();
    if (eos) begin
      abort_esc(ErrEarlyEnd);
    end else begin
      case (esc_ph)
        PH_NORMAL: begin
          if (c == ChBslash) esc_ph = PH_ESC;
          else if (c == ChQuote) put_res(8'h00, KindClose, ErrNone);
          else if (c == 8'h00) nul_char();
          else put_res(c, KindData, ErrNone);
        end
        PH_ESC: begin
          esc_ph = PH_NORMAL;
          case (c)
            ChQuote, ChSlash, ChBslash: put_res(c, KindData, ErrNone);
            ChB: put_res(CtlBs, KindData, ErrNone);
            ChF: put_res(CtlFf, KindData, ErrNone);
            ChN: put_res(CtlLf, KindData, ErrNone);
            ChR: put_res(CtlCr, KindData, ErrNone);
            ChT: put_res(CtlTab, KindData, ErrNone);
            ChZero: nul_char();
            ChU: begin
              esc_ph = PH_HEX1;
              hcnt = 2'd0;
              hacc = 16'h0000;
            end
            default: abort_esc(ErrEscape);
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          d = hex_digit(c);
          if (d < 0) begin
            abort_esc(ErrHex);
          end else begin
            hacc = {hacc[11:0], d[3:0]};
            if (hcnt < 2'd3) begin
              hcnt++;
            end else begin
              v = hacc;
              hcnt = 2'd0;
              hacc = 16'h0000;
              if (esc_ph == PH_HEX1) begin
                if (v >= LowFirst && v < LowEnd) begin
                  abort_esc(ErrSurrogate);
                end else if (v >= HighFirst && v < LowFirst) begin
                  hhalf = v[9:0];
                  esc_ph = PH_BSLASH;
                end else begin
                  esc_ph = PH_NORMAL;
                  put_utf8({5'd0, v});
                end
              end else if (v < LowFirst || v >= LowEnd) begin
                abort_esc(ErrSurrogate);
              end else begin
                cp = {hhalf, 10'd0} + (v - LowFirst) + SuppBase;
                clear_esc();
                put_utf8(cp);
              end
            end
          end
        end
        PH_BSLASH: begin
          if (c != ChBslash) abort_esc(ErrSurrogate);
          else esc_ph = PH_LOWU;
        end
        PH_LOWU: begin
          if (c != ChU) begin
            abort_esc(ErrSurrogate);
          end else begin
            esc_ph = PH_HEX2;
            hcnt = 2'd0;
            hacc = 16'h0000;
          end
        end
        default: clear_esc();
      endcase
    end
    if (step_out.size() > 0) step_out[$].last = 1'b1;
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic send_req(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_req++;
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic eos);
    send_req(b, eos);
    unescape_step(b, eos);
    foreach (step_out[i]) decoded_q.insert(decoded_q.size(), step_out[i]);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    // room for a request still inside the block with nothing to show for it
    repeat (8) @(posedge clk);
  endtask

  task automatic write_nul_cfg(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    nul_ok = v;
  endtask

  task automatic push_req(input logic [7:0] b, input logic eos);
    req_t r;
    r.b = b;
    r.eos = eos;
    tok.insert(tok.size(), r);
  endtask

  task automatic push_uesc(input logic [15:0] v);
    logic [3:0] nib;
    logic [7:0] ch;
    push_req(ChBslash, 1'b0);
    push_req(ChU, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) begin
        ch = "0";
        ch = ch + nib;
      end else begin
        ch = $urandom_range(1) ? "a" : "A";
        ch = ch + nib - 8'd10;
      end
      push_req(ch, 1'b0);
    end
  endtask

  // mostly well-formed escapes with random content, some broken ones and noise
  task automatic build_token();
    int pick;
    int cut;
    logic [15:0] v;
    tok.delete();
    pick = $urandom_range(99);
    if (pick < 28) begin
      cut = $urandom_range(19);
      if (cut < 2) push_req(ChQuote, 1'b0);
      else if (cut < 3) push_req(8'h00, 1'b0);
      else push_req(8'($urandom_range(255)), 1'b0);
    end else if (pick < 48) begin
      push_req(ChBslash, 1'b0);
      push_req(esc_letters[$urandom_range(8)], 1'b0);
    end else if (pick < 66) begin
      case ($urandom_range(4))
        0: v = 16'($urandom_range(16'h007F));
        1: v = 16'($urandom_range(16'h07FF, 16'h0080));
        2: v = 16'($urandom_range(16'hD7FF, 16'h0800));
        3: v = 16'($urandom_range(16'hFFFF, 16'hE000));
        default: v = 16'h0000;
      endcase
      push_uesc(v);
    end else if (pick < 80) begin
      push_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
      push_uesc(16'($urandom_range(16'hDFFF, 16'hDC00)));
    end else if (pick < 94) begin
      push_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
      case ($urandom_range(5))
        0: begin
          tok.delete();
          push_req(ChBslash, 1'b0);
          push_req(8'($urandom_range(255)), 1'b0);
        end
        1: begin
          tok.delete();
          push_uesc(16'($urandom_range(16'hFFFF)));
          tok[$urandom_range(5, 2)].b = 8'($urandom_range(255));
        end
        2: begin
          tok.delete();
          push_uesc(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        3: push_req(8'($urandom_range(255)), 1'b0);
        4: begin
          push_req(ChBslash, 1'b0);
          push_req(8'($urandom_range(255)), 1'b0);
        end
        default: push_uesc(16'($urandom_range(16'hFFFF)));
      endcase
    end else begin
      push_req(8'($urandom_range(255)), 1'b1);
    end
    // input ends in the middle of an escape now and then
    if (tok.size() > 1 && $urandom_range(99) < 6) begin
      cut = $urandom_range(tok.size() - 1, 1);
      while (tok.size() > cut) void'(tok.pop_back());
      push_req(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // ---------------- result side ----------------

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_res++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %h kind %0d error_code %0d last_of_run %0d",
               out_tdata, out_tuser[1:0], out_tuser[4:2], out_tlast);
        n_err++;
      end else begin
        want = decoded_q.pop_front();
        if (want.kind == KindClose) n_close++;
        if (want.kind == KindError) n_fault++;
        if (out_tdata !== want.data) begin
          $error("out_byte mismatch: expected %h, actual %h", want.data, out_tdata);
          n_err++;
        end
        if (out_tuser[1:0] !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, out_tuser[1:0]);
          n_err++;
        end
        if (out_tuser[4:2] !== want.err) begin
          $error("error_code mismatch: expected %0d, actual %0d", want.err, out_tuser[4:2]);
          n_err++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run mismatch: expected %0d, actual %0d", want.last, out_tlast);
          n_err++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    int target;
    res_t r;
    clear_esc();
    nul_ok = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 26; k++) begin
      if (dir_tab[k].nul != nul_ok) begin
        drain_outputs();
        write_nul_cfg(dir_tab[k].nul);
      end
      send_req(dir_tab[k].b, dir_tab[k].eos);
      unescape_step(dir_tab[k].b, dir_tab[k].eos);
      if (dir_tab[k].typed) begin
        r.data = dir_tab[k].data;
        r.kind = dir_tab[k].kind;
        r.err  = dir_tab[k].err;
        r.last = 1'b1;
        decoded_q.insert(decoded_q.size(), r);
      end else begin
        foreach (step_out[i]) decoded_q.insert(decoded_q.size(), step_out[i]);
      end
    end

    for (int stage = 0; stage < 3; stage++) begin
      drain_outputs();
      write_nul_cfg(stage == 1);
      send_idle = (stage == 0) ? 31 : (stage == 1) ? 72 : 0;
      recv_idle = (stage == 0) ? 72 : (stage == 1) ? 31 : 0;
      // long output stall while requests keep coming
      if (stage == 2) hold_left = 300;
      target = n_req + 108;
      while (n_req < target) begin
        build_token();
        foreach (tok[i]) send_predicted(tok[i].b, tok[i].eos);
      end
    end

    drain_outputs();
    $display("covered %0d requests with allow_nul at 0 and 1, three pacing modes and a long stall",
             n_req);
    $display("%0d results checked: %0d string closes, %0d error reports",
             n_res, n_close, n_fault);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", decoded_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/jsu_pkg.sv
rtl/core/json_string_unescaper_unit.sv
sim/tb.sv
